### rtl/gwwl_pkg.sv
// Shared types, constants and helper functions for the greedy word-wrap layout block.
`timescale 1ns / 1ps

package gwwl_pkg;

    localparam int CODE_W     = 21;
    localparam int ADV_W      = 8;
    localparam int POS_W      = 16;
    localparam int PITCH_W    = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CODE_W-1:0] CH_NULL    = 21'd0;
    localparam logic [CODE_W-1:0] CH_NEWLINE = 21'd10;
    localparam logic [CODE_W-1:0] CH_SPACE   = 21'd32;

    localparam logic [CFG_IDX_W-1:0] REG_WRAP_LIMIT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH = 8'd1;

    localparam logic [PITCH_W-1:0] PITCH_RESET = 8'd16;

    typedef struct packed {
        logic              found;
        logic [ADV_W-1:0]  adv;
        logic [CODE_W-1:0] code;
    } t_entry;

    typedef struct packed {
        logic [CODE_W-1:0] glyph_code;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [POS_W-1:0]  glyph_index;
    } t_result;

    typedef struct packed {
        logic push;
        logic flush;
    } t_oq_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRE,
        S_PLACE,
        S_POST,
        S_EOT,
        S_FIN
    } t_state;

    function automatic logic [POS_W-1:0] sat_add16(input logic [POS_W-1:0] a,
                                                   input logic [POS_W-1:0] b);
        logic [POS_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[POS_W] ? {POS_W{1'b1}} : s[POS_W-1:0];
    endfunction

    // A zero limit disables wrapping; a pen at the line start never wraps.
    function automatic logic wrap_hit(input logic [POS_W-1:0] limit,
                                      input logic [POS_W-1:0] col,
                                      input logic [POS_W-1:0] w);
        logic [POS_W:0] s;
        s = {1'b0, col} + {1'b0, w};
        return (limit != '0) && (col != '0) && (s > {1'b0, limit});
    endfunction

endpackage

### rtl/gwwl_out_reg.sv
// Result holding stage: one pending result plus the output register, which marks the last one.
`timescale 1ns / 1ps

module gwwl_out_reg
    import gwwl_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_oq_ctl             i_ctl,
    input  t_result             i_result,
    output logic                o_slot_ok,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [CODE_W-1:0]   o_glyph_code,
    output logic [POS_W-1:0]    o_pos_x,
    output logic [POS_W-1:0]    o_pos_y,
    output logic [POS_W-1:0]    o_glyph_index,
    output logic                o_run_last
);

    logic    r_out_valid, n_out_valid;
    logic    r_pend_valid, n_pend_valid;
    t_result r_pend, n_pend;
    t_result r_out, n_out;
    logic    r_out_last, n_out_last;
    logic    out_free;

    assign out_free  = !r_out_valid || !i_stall;
    assign o_slot_ok = !r_pend_valid || out_free;

    // The newest result waits in the pending slot until the next one, or the end
    // of the request, tells whether it is the last.
    always_comb begin
        n_out_valid  = r_out_valid && i_stall;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out        = r_out;
        n_out_last   = r_out_last;
        if (i_ctl.push) begin
            if (r_pend_valid) begin
                n_out       = r_pend;
                n_out_last  = 1'b0;
                n_out_valid = 1'b1;
            end
            n_pend       = i_result;
            n_pend_valid = 1'b1;
        end else if (i_ctl.flush && r_pend_valid) begin
            n_out        = r_pend;
            n_out_last   = 1'b1;
            n_out_valid  = 1'b1;
            n_pend_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend     <= n_pend;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    assign o_valid       = r_out_valid;
    assign o_glyph_code  = r_out.glyph_code;
    assign o_pos_x       = r_out.pos_x;
    assign o_pos_y       = r_out.pos_y;
    assign o_glyph_index = r_out.glyph_index;
    assign o_run_last    = r_out_last;

endmodule

### rtl/greedy_word_wrap_layout.sv
// Top level of the greedy word-wrap layout block: word buffer memory and layout sequencer.
`timescale 1ns / 1ps
//
// One decoded character enters per request on the input channel (i_valid / o_stall);
// placed glyphs leave on the output channel (o_valid / i_stall), o_run_last marking
// the last glyph caused by a request. Ordinary characters are written into a word
// buffer memory; a space, newline, zero code point, full buffer or end of text closes
// the word and the sequencer reads it back one entry per cycle unless a glyph finds
// the output stage full, placing each glyph. A request is taken only in the idle
// state, so a new one waits until the last is through. A buffered character passes
// accept, dispatch, store and finish; a request that closes a word also reads back
// each buffered character through the single read port of the word buffer. One
// result is held back until the next shows whether it is the last. Configuration
// writes (i_cfg_valid, always ready) are taken at any time and are meant for idle
// periods. Synchronous reset clears pen, counters and word length, zeroes the wrap
// limit and sets the line pitch to 16; the buffer memory itself needs no clearing.
// When the receiver stalls, the output register and one pending result fill, then
// the sequencer waits.

module greedy_word_wrap_layout
    import gwwl_pkg::*;
#(
    parameter int WORD_MAX = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [CODE_W-1:0]     i_code_point,
    input  logic [ADV_W-1:0]      i_advance_px,
    input  logic                  i_glyph_found,
    input  logic                  i_end_of_text,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [CODE_W-1:0]     o_glyph_code,
    output logic [POS_W-1:0]      o_pos_x,
    output logic [POS_W-1:0]      o_pos_y,
    output logic [POS_W-1:0]      o_glyph_index,
    output logic                  o_run_last,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW  = $clog2(WORD_MAX);
    localparam int LW  = $clog2(WORD_MAX + 1);
    localparam int PXW = $clog2(WORD_MAX * (2 ** ADV_W - 1) + 1);

    t_state              r_state, n_state;
    logic [CODE_W-1:0]   r_code, n_code;
    logic [ADV_W-1:0]    r_adv, n_adv;
    logic                r_found, n_found;
    logic                r_eot, n_eot;
    logic                r_phase_eot, n_phase_eot;
    logic [LW-1:0]       r_word_len, n_word_len;
    logic [PXW-1:0]      r_word_px, n_word_px;
    logic [POS_W-1:0]    r_first, n_first;
    logic [POS_W-1:0]    r_col, n_col;
    logic [POS_W-1:0]    r_row, n_row;
    logic [POS_W-1:0]    r_cnt, n_cnt;
    logic [AW-1:0]       r_idx, n_idx;
    logic [POS_W-1:0]    r_wrap;
    logic [PITCH_W-1:0]  r_pitch;
    t_entry              r_rd;
    t_entry              mem [WORD_MAX];

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    t_entry              mem_wdata;
    logic [AW-1:0]       rd_addr;
    t_oq_ctl             oq_ctl;
    t_result             res;
    logic                slot_ok;

    logic [POS_W-1:0]    row_nl;
    logic                is_null, is_space, is_newline;
    logic                need_close;
    logic                hit;
    logic [POS_W-1:0]    col_w, row_w;
    logic                advance, last, place;
    logic [ADV_W-1:0]    space_w;

    assign row_nl     = sat_add16(r_row, POS_W'(r_pitch));
    assign is_null    = (r_code == CH_NULL);
    assign is_space   = (r_code == CH_SPACE);
    assign is_newline = (r_code == CH_NEWLINE);
    assign o_stall    = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state     = r_state;
        n_code      = r_code;
        n_adv       = r_adv;
        n_found     = r_found;
        n_eot       = r_eot;
        n_phase_eot = r_phase_eot;
        n_word_len  = r_word_len;
        n_word_px   = r_word_px;
        n_first     = r_first;
        n_col       = r_col;
        n_row       = r_row;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        mem_we      = 1'b0;
        mem_waddr   = r_word_len[AW-1:0];
        mem_wdata   = '{found: r_found, adv: r_adv, code: r_code};
        rd_addr     = '0;
        oq_ctl      = '0;
        res         = '0;
        need_close  = 1'b0;
        hit         = 1'b0;
        col_w       = r_col;
        row_w       = r_row;
        advance     = 1'b0;
        last        = 1'b0;
        place       = 1'b0;
        space_w     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_code  = i_code_point;
                    n_adv   = i_advance_px;
                    n_found = i_glyph_found;
                    n_eot   = i_end_of_text;
                    n_state = S_PRE;
                end
            end

            S_PRE: begin
                // A zero code point closes even an empty word, so its line check still runs.
                need_close = is_null
                          || ((is_space || is_newline) && r_word_len != '0)
                          || (!is_space && !is_newline
                              && r_word_len >= LW'(WORD_MAX));
                n_state = S_POST;
                if (need_close) begin
                    if (wrap_hit(r_wrap, r_col, POS_W'(r_word_px))) begin
                        n_col = '0;
                        n_row = row_nl;
                    end
                    n_phase_eot = 1'b0;
                    if (r_word_len != '0) begin
                        n_idx   = '0;
                        n_state = S_PLACE;
                    end
                end
            end

            S_PLACE: begin
                hit   = wrap_hit(r_wrap, r_col, POS_W'(r_rd.adv));
                col_w = hit ? '0 : r_col;
                row_w = hit ? row_nl : r_row;
                res   = '{glyph_code: r_rd.code, pos_x: col_w, pos_y: row_w,
                          glyph_index: sat_add16(r_first, POS_W'(r_idx))};
                advance = !r_rd.found || slot_ok;
                last    = (LW'(r_idx) + LW'(1)) == r_word_len;
                // Read ahead so that the next entry is registered by the next cycle.
                rd_addr = advance ? r_idx + AW'(1) : r_idx;
                if (advance) begin
                    if (r_rd.found) begin
                        oq_ctl.push = 1'b1;
                        n_col = sat_add16(col_w, POS_W'(r_rd.adv));
                        n_row = row_w;
                    end
                    if (last) begin
                        n_word_len = '0;
                        n_word_px  = '0;
                        n_state    = r_phase_eot ? S_FIN : S_POST;
                    end else begin
                        n_idx = r_idx + AW'(1);
                    end
                end
            end

            S_POST: begin
                priority if (is_space) begin
                    space_w = r_found ? r_adv : '0;
                    hit     = wrap_hit(r_wrap, r_col, POS_W'(space_w));
                    col_w   = hit ? '0 : r_col;
                    row_w   = hit ? row_nl : r_row;
                    // A space that would start a line is dropped.
                    place   = r_found && (col_w != '0);
                    res     = '{glyph_code: r_code, pos_x: col_w, pos_y: row_w,
                                glyph_index: r_cnt};
                    if (!place || slot_ok) begin
                        n_cnt = sat_add16(r_cnt, POS_W'(1));
                        n_col = col_w;
                        n_row = row_w;
                        if (place) begin
                            oq_ctl.push = 1'b1;
                            n_col = sat_add16(col_w, POS_W'(r_adv));
                        end
                        n_state = r_eot ? S_EOT : S_FIN;
                    end
                end else if (is_newline) begin
                    n_cnt   = sat_add16(r_cnt, POS_W'(1));
                    n_col   = '0;
                    n_row   = row_nl;
                    n_state = r_eot ? S_EOT : S_FIN;
                end else if (is_null) begin
                    n_state = r_eot ? S_EOT : S_FIN;
                end else begin
                    mem_we = 1'b1;
                    if (r_word_len == '0) begin
                        n_first = r_cnt;
                    end
                    n_word_len = r_word_len + LW'(1);
                    if (r_found) begin
                        n_word_px = r_word_px + PXW'(r_adv);
                    end
                    n_cnt   = sat_add16(r_cnt, POS_W'(1));
                    n_state = r_eot ? S_EOT : S_FIN;
                end
            end

            S_EOT: begin
                n_state = S_FIN;
                if (r_word_len != '0) begin
                    if (wrap_hit(r_wrap, r_col, POS_W'(r_word_px))) begin
                        n_col = '0;
                        n_row = row_nl;
                    end
                    n_idx       = '0;
                    n_phase_eot = 1'b1;
                    n_state     = S_PLACE;
                end
            end

            S_FIN: begin
                if (slot_ok) begin
                    oq_ctl.flush = 1'b1;
                    if (r_eot) begin
                        n_word_len = '0;
                        n_word_px  = '0;
                        n_first    = '0;
                        n_col      = '0;
                        n_row      = '0;
                        n_cnt      = '0;
                    end
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_word_len <= '0;
            r_word_px  <= '0;
            r_first    <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_cnt      <= '0;
        end else begin
            r_state    <= n_state;
            r_word_len <= n_word_len;
            r_word_px  <= n_word_px;
            r_first    <= n_first;
            r_col      <= n_col;
            r_row      <= n_row;
            r_cnt      <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code      <= n_code;
        r_adv       <= n_adv;
        r_found     <= n_found;
        r_eot       <= n_eot;
        r_phase_eot <= n_phase_eot;
        r_idx       <= n_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap  <= '0;
            r_pitch <= PITCH_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_WRAP_LIMIT) begin
                r_wrap <= i_cfg_data;
            end else if (i_cfg_index == REG_LINE_PITCH) begin
                r_pitch <= i_cfg_data[PITCH_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= mem[rd_addr];
    end

    gwwl_out_reg u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (oq_ctl),
        .i_result      (res),
        .o_slot_ok     (slot_ok),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_glyph_code  (o_glyph_code),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_glyph_index (o_glyph_index),
        .o_run_last    (o_run_last)
    );

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        oq_ctl.push |-> slot_ok)
        else $error("result pushed with no room in the output stage");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_word_len <= LW'(WORD_MAX))
        else $error("word length beyond buffer depth");

    a_place_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PLACE) |-> (r_word_len != '0))
        else $error("word readback with an empty word");

    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_PRE))
        else $error("accepted request not dispatched");

    a_store_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_word_len < LW'(WORD_MAX)))
        else $error("word buffer written past its end");

endmodule
